// ===== hdl/dtc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the detection track confirmation block.
// No dependencies.
package dtc_pkg;

   localparam int ReqDataWidth = 64;
   localparam int RspDataWidth = 88;
   localparam int CsrAddrWidth = 3;
   localparam int CsrDataWidth = 16;

   // frame kinds carried on req_tuser
   typedef enum logic [1:0] {
      OP_NO_DET = 2'd0,
      OP_DET    = 2'd1,
      OP_CLEAR  = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   // register indexes
   localparam logic [CsrAddrWidth-1:0] RegConfirmFrames  = 3'd0;
   localparam logic [CsrAddrWidth-1:0] RegConfMissLimit  = 3'd1;
   localparam logic [CsrAddrWidth-1:0] RegPendMissLimit  = 3'd2;
   localparam logic [CsrAddrWidth-1:0] RegCenterLimit    = 3'd3;
   localparam logic [CsrAddrWidth-1:0] RegSlopeLimit     = 3'd4;
   localparam logic [CsrAddrWidth-1:0] RegYawLimit       = 3'd5;

   localparam logic [7:0]  ConfirmFramesReset = 8'd5;
   localparam logic [7:0]  ConfMissLimitReset = 8'd8;
   localparam logic [7:0]  PendMissLimitReset = 8'd2;
   localparam logic [15:0] CenterLimitReset   = 16'd600;
   localparam logic [31:0] CenterLimitSqReset = 32'd360000;
   localparam logic [12:0] SlopeLimitReset    = 13'd546;
   localparam logic [14:0] YawLimitReset      = 15'd2731;

   localparam logic [15:0] YawHalfTurn = 16'h8000;

   typedef struct packed {
      logic signed [15:0] cx;
      logic signed [15:0] cy;
      logic [12:0]        slope;
      logic [15:0]        yaw;
   } track_type;

endpackage

// ===== hdl/detection_track_confirmation.sv =====
`timescale 1ns / 1ps
// Detection track confirmation by counted matches, with coasting, for one region.
// Depends on dtc_pkg.
//
// Usage:
//  req channel: one word per detection frame. req_tuser is the frame kind
//  (no detection, detection, clear; the unused code leaves the tracks as they
//  are). req_tdata carries center x/y in mm, slope and yaw binary angles.
//  rsp channel: one word per frame with the track status after that frame.
//  csr port: write-only, one register per index, written while idle.
// A req word passes the input register and then the result register to rsp.
// Throughput: one frame per cycle while rsp is not stalled. The frame sits
// in an input register; the compare (two 17x17 squares, sum, limit compare)
// and the track update run in one pass and land in the state and the result
// register together, so the next frame sees the updated tracks right away.
// A stalled rsp holds the result; the input register still takes one more
// word, then req_tready drops until the result drains.
// Reset: tracks and counters are cleared, registers go to their defaults.
// The center limit is squared as it is written.
module detection_track_confirmation (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [15:0] center_x_mm, [31:16] center_y_mm, [44:32] slope_angle,
   // [60:45] yaw_angle, [63:61] zero
   input  logic [dtc_pkg::ReqDataWidth-1:0]    req_tdata,
   // [1:0] op
   input  logic [1:0]                          req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [0] confirmed_valid, [1] pending_valid, [17:2] track_x_mm,
   // [33:18] track_y_mm, [46:34] track_slope, [62:47] track_yaw,
   // [70:63] confirm_count, [78:71] pending_misses, [86:79] confirmed_misses,
   // [87] zero
   output logic [dtc_pkg::RspDataWidth-1:0]    rsp_tdata,
   input  logic                                csr_we,
   input  logic [dtc_pkg::CsrAddrWidth-1:0]    csr_addr,
   input  logic [dtc_pkg::CsrDataWidth-1:0]    csr_wdata
);
   import dtc_pkg::*;

   // config registers
   logic [7:0]  confirm_frames_ff;
   logic [7:0]  conf_miss_limit_ff;
   logic [7:0]  pend_miss_limit_ff;
   logic [31:0] center_limit_sq_ff;
   logic [12:0] slope_limit_ff;
   logic [14:0] yaw_limit_ff;

   // input stage
   logic        in_vld_ff;
   op_type      in_op_ff;
   track_type   in_det_ff;

   // track state
   logic        pend_present_ff, pend_present_in;
   track_type   pend_trk_ff, pend_trk_in;
   logic        conf_present_ff, conf_present_in;
   track_type   conf_trk_ff, conf_trk_in;
   logic [7:0]  match_cnt_ff, match_cnt_in;
   logic [7:0]  pend_miss_ff, pend_miss_in;
   logic [7:0]  conf_miss_ff, conf_miss_in;

   // result stage
   logic                    rsp_vld_ff;
   logic [RspDataWidth-1:0] rsp_data_ff, rsp_data_in;

   logic        advance;
   logic        fire;
   logic [7:0]  need;
   logic        conf_match;
   logic        pend_match;
   logic [8:0]  pend_miss_inc;
   logic [8:0]  conf_miss_inc;
   logic [8:0]  match_inc;
   logic [7:0]  match_next;

   function automatic logic trk_match(
      input track_type   a,
      input track_type   b,
      input logic [31:0] lim_sq,
      input logic [12:0] slope_lim,
      input logic [14:0] yaw_lim
   );
      logic signed [16:0] dx;
      logic signed [16:0] dy;
      logic signed [33:0] px;
      logic signed [33:0] py;
      logic [33:0]        dist2;
      logic [12:0]        ds;
      logic [15:0]        d;
      logic [15:0]        dw;
      dx    = {a.cx[15], a.cx} - {b.cx[15], b.cx};
      dy    = {a.cy[15], a.cy} - {b.cy[15], b.cy};
      px    = dx * dx;
      py    = dy * dy;
      dist2 = {1'b0, px[32:0]} + {1'b0, py[32:0]};
      ds    = (a.slope >= b.slope) ? (a.slope - b.slope) : (b.slope - a.slope);
      d     = a.yaw - b.yaw;
      dw    = (d > YawHalfTurn) ? (16'd0 - d) : d;
      return (dist2 <= {2'b00, lim_sq}) && (ds <= slope_lim) && (dw <= {1'b0, yaw_lim});
   endfunction

   assign advance    = !rsp_vld_ff || rsp_tready;
   assign fire       = in_vld_ff && advance;
   assign req_tready = !in_vld_ff || advance;
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

   // config writes; the center limit is kept squared for the compare
   always_ff @(posedge clock) begin
      if (reset) begin
         confirm_frames_ff  <= ConfirmFramesReset;
         conf_miss_limit_ff <= ConfMissLimitReset;
         pend_miss_limit_ff <= PendMissLimitReset;
         center_limit_sq_ff <= CenterLimitSqReset;
         slope_limit_ff     <= SlopeLimitReset;
         yaw_limit_ff       <= YawLimitReset;
      end else begin
         if (csr_we) begin
            unique case (csr_addr)
               RegConfirmFrames: confirm_frames_ff  <= csr_wdata[7:0];
               RegConfMissLimit: conf_miss_limit_ff <= csr_wdata[7:0];
               RegPendMissLimit: pend_miss_limit_ff <= csr_wdata[7:0];
               RegCenterLimit:   center_limit_sq_ff <= {16'd0, csr_wdata} * {16'd0, csr_wdata};
               RegSlopeLimit:    slope_limit_ff     <= csr_wdata[12:0];
               RegYawLimit:      yaw_limit_ff       <= csr_wdata[14:0];
               default: ;
            endcase
         end
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_tready) begin
         in_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_op_ff        <= op_type'(req_tuser);
         in_det_ff.cx    <= req_tdata[15:0];
         in_det_ff.cy    <= req_tdata[31:16];
         in_det_ff.slope <= req_tdata[44:32];
         in_det_ff.yaw   <= req_tdata[60:45];
      end
   end

   assign need       = (confirm_frames_ff == 8'd0) ? 8'd1 : confirm_frames_ff;
   assign conf_match = trk_match(conf_trk_ff, in_det_ff, center_limit_sq_ff,
                                 slope_limit_ff, yaw_limit_ff);
   assign pend_match = trk_match(pend_trk_ff, in_det_ff, center_limit_sq_ff,
                                 slope_limit_ff, yaw_limit_ff);
   assign pend_miss_inc = {1'b0, pend_miss_ff} + 9'd1;
   assign conf_miss_inc = {1'b0, conf_miss_ff} + 9'd1;
   assign match_inc     = {1'b0, match_cnt_ff} + 9'd1;

   always_comb begin
      match_next = 8'd1;
      if (pend_present_ff && pend_match) begin
         match_next = (match_inc > {1'b0, need}) ? need : match_inc[7:0];
      end
   end

   // track update
   always_comb begin
      pend_present_in = pend_present_ff;
      pend_trk_in     = pend_trk_ff;
      conf_present_in = conf_present_ff;
      conf_trk_in     = conf_trk_ff;
      match_cnt_in    = match_cnt_ff;
      pend_miss_in    = pend_miss_ff;
      conf_miss_in    = conf_miss_ff;

      unique case (in_op_ff)
         OP_NO_DET: begin
            if (pend_present_ff) begin
               if (pend_miss_inc > {1'b0, pend_miss_limit_ff}) begin
                  pend_present_in = 1'b0;
                  pend_miss_in    = 8'd0;
                  match_cnt_in    = 8'd0;
               end else begin
                  pend_miss_in = pend_miss_inc[7:0];
               end
            end
            if (conf_present_ff) begin
               if (conf_miss_inc > {1'b0, conf_miss_limit_ff}) begin
                  conf_present_in = 1'b0;
                  conf_miss_in    = 8'd0;
               end else begin
                  conf_miss_in = conf_miss_inc[7:0];
               end
            end
         end
         OP_DET: begin
            if (conf_present_ff) begin
               if (conf_match) begin
                  conf_trk_in  = in_det_ff;
                  conf_miss_in = 8'd0;
               end else if (conf_miss_inc > {1'b0, conf_miss_limit_ff}) begin
                  conf_present_in = 1'b0;
                  conf_miss_in    = 8'd0;
               end else begin
                  conf_miss_in = conf_miss_inc[7:0];
               end
            end
            match_cnt_in    = match_next;
            pend_trk_in     = in_det_ff;
            pend_present_in = 1'b1;
            pend_miss_in    = 8'd0;
            if (match_next >= need) begin
               conf_trk_in     = in_det_ff;
               conf_present_in = 1'b1;
               conf_miss_in    = 8'd0;
            end
         end
         OP_CLEAR: begin
            pend_present_in = 1'b0;
            conf_present_in = 1'b0;
            match_cnt_in    = 8'd0;
            pend_miss_in    = 8'd0;
            conf_miss_in    = 8'd0;
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp_data_in        = '0;
      rsp_data_in[0]     = conf_present_in;
      rsp_data_in[1]     = pend_present_in;
      if (conf_present_in) begin
         rsp_data_in[17:2]  = conf_trk_in.cx;
         rsp_data_in[33:18] = conf_trk_in.cy;
         rsp_data_in[46:34] = conf_trk_in.slope;
         rsp_data_in[62:47] = conf_trk_in.yaw;
      end
      rsp_data_in[70:63] = match_cnt_in;
      rsp_data_in[78:71] = pend_miss_in;
      rsp_data_in[86:79] = conf_miss_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_present_ff <= 1'b0;
         conf_present_ff <= 1'b0;
         match_cnt_ff    <= 8'd0;
         pend_miss_ff    <= 8'd0;
         conf_miss_ff    <= 8'd0;
         rsp_vld_ff      <= 1'b0;
      end else begin
         if (fire) begin
            pend_present_ff <= pend_present_in;
            conf_present_ff <= conf_present_in;
            match_cnt_ff    <= match_cnt_in;
            pend_miss_ff    <= pend_miss_in;
            conf_miss_ff    <= conf_miss_in;
         end
         if (advance) begin
            rsp_vld_ff <= in_vld_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         pend_trk_ff <= pend_trk_in;
         conf_trk_ff <= conf_trk_in;
         rsp_data_ff <= rsp_data_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_conf_miss_idle: assert property (@(posedge clock) disable iff (reset)
      !conf_present_ff |-> conf_miss_ff == 8'd0)
      else $error("confirmed miss count set without a confirmed track");

   a_match_tracks_pending: assert property (@(posedge clock) disable iff (reset)
      pend_present_ff == (match_cnt_ff != 8'd0))
      else $error("match count out of step with pending track");

   a_confirm_from_pending: assert property (@(posedge clock) disable iff (reset)
      $rose(conf_present_ff) |-> pend_present_ff && $past(in_op_ff) == OP_DET)
      else $error("track confirmed without a detection");
`endif

endmodule

// ===== test/tb_detection_track_confirmation.sv =====
`timescale 1ns / 1ps
// Testbench for detection_track_confirmation: streams detection frames on req, predicts each
// status word with a behavioral track model and compares it field by field on rsp.
// Depends on dtc_pkg and the detection_track_confirmation RTL.
module tb_detection_track_confirmation;
   import dtc_pkg::*;

   localparam int CycleLimit = 1000000;

   // req_tdata layout, lowest field last
   typedef struct packed {
      logic [2:0]         pad;
      logic [15:0]        yaw;
      logic [12:0]        slope;
      logic signed [15:0] cy;
      logic signed [15:0] cx;
   } frame_word_type;

   // rsp_tdata layout, lowest field last
   typedef struct packed {
      logic               pad;
      logic [7:0]         conf_misses;
      logic [7:0]         pend_misses;
      logic [7:0]         hits;
      logic [15:0]        yaw;
      logic [12:0]        slope;
      logic signed [15:0] y;
      logic signed [15:0] x;
      logic               pend_on;
      logic               conf_on;
   } status_word_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [ReqDataWidth-1:0] req_tdata = '0;
   logic [1:0]              req_tuser = OP_NO_DET;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RspDataWidth-1:0] rsp_tdata;
   logic                    csr_we = 1'b0;
   logic [CsrAddrWidth-1:0] csr_addr = '0;
   logic [CsrDataWidth-1:0] csr_wdata = '0;

   // register copies
   int lim_confirm   = ConfirmFramesReset;
   int lim_conf_miss = ConfMissLimitReset;
   int lim_pend_miss = PendMissLimitReset;
   int lim_center    = CenterLimitReset;
   int lim_slope     = SlopeLimitReset;
   int lim_yaw       = YawLimitReset;

   // track state of the model
   bit        pend_on = 1'b0;
   bit        conf_on = 1'b0;
   track_type pend_trk = '0;
   track_type conf_trk = '0;
   int        hits = 0;
   int        pend_misses = 0;
   int        conf_misses = 0;

   status_word_type status_expected[$];
   status_word_type got_word, want_word;
   int err_count = 0;
   int frames_sent = 0;
   int words_checked = 0;
   int confirm_events = 0;
   int cycle_count = 0;
   bit req_gap_on = 1'b1;
   bit rsp_stall_on = 1'b1;
   int rsp_hold_req = 0;
   int rsp_hold_left = 0;
   int rsp_stall_left = 0;

   detection_track_confirmation dut (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("tb_detection_track_confirmation: done, errors");
         $finish;
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic track_type make_track(int cx, int cy, int slope, int yaw);
      track_type t;
      t.cx = 16'(cx);
      t.cy = 16'(cy);
      t.slope = 13'(slope);
      t.yaw = 16'(yaw);
      return t;
   endfunction

   function automatic track_type random_track();
      return make_track($urandom, $urandom, $urandom_range(0, 8191), $urandom);
   endfunction

   function automatic bit track_near(track_type a, track_type b);
      longint dx, dy, lim;
      int ds, dyaw;
      logic [15:0] yaw_diff;
      dx = longint'(a.cx) - longint'(b.cx);
      dy = longint'(a.cy) - longint'(b.cy);
      lim = longint'(lim_center);
      ds = int'(a.slope) - int'(b.slope);
      if (ds < 0) ds = -ds;
      yaw_diff = a.yaw - b.yaw;
      dyaw = (yaw_diff > YawHalfTurn) ? 65536 - int'(yaw_diff) : int'(yaw_diff);
      return (dx * dx + dy * dy <= lim * lim) && ds <= lim_slope && dyaw <= lim_yaw;
   endfunction

   function automatic void coast_confirmed();
      if (conf_misses + 1 > lim_conf_miss) begin
         conf_on = 1'b0;
         conf_trk = '0;
         conf_misses = 0;
      end else begin
         conf_misses++;
      end
   endfunction

   // advances the track model by one frame and returns the status word it should produce
   function automatic status_word_type predict_frame(op_type op, track_type det);
      status_word_type s;
      int need;
      need = (lim_confirm == 0) ? 1 : lim_confirm;
      case (op)
         OP_NO_DET: begin
            if (pend_on) begin
               if (pend_misses + 1 > lim_pend_miss) begin
                  pend_on = 1'b0;
                  pend_trk = '0;
                  pend_misses = 0;
                  hits = 0;
               end else begin
                  pend_misses++;
               end
            end
            if (conf_on) coast_confirmed();
         end
         OP_DET: begin
            if (conf_on) begin
               if (track_near(conf_trk, det)) begin
                  conf_trk = det;
                  conf_misses = 0;
               end else begin
                  coast_confirmed();
               end
            end
            if (pend_on && track_near(pend_trk, det)) hits = (hits + 1 > need) ? need : hits + 1;
            else hits = 1;
            pend_trk = det;
            pend_on = 1'b1;
            pend_misses = 0;
            if (hits >= need) begin
               if (!conf_on) confirm_events++;
               conf_trk = det;
               conf_on = 1'b1;
               conf_misses = 0;
            end
         end
         OP_CLEAR: begin
            pend_on = 1'b0;
            conf_on = 1'b0;
            pend_trk = '0;
            conf_trk = '0;
            hits = 0;
            pend_misses = 0;
            conf_misses = 0;
         end
         default: ;
      endcase
      s = '0;
      s.conf_on = conf_on;
      s.pend_on = pend_on;
      if (conf_on) begin
         s.x = conf_trk.cx;
         s.y = conf_trk.cy;
         s.slope = conf_trk.slope;
         s.yaw = conf_trk.yaw;
      end
      s.hits = 8'(hits);
      s.pend_misses = 8'(pend_misses);
      s.conf_misses = 8'(conf_misses);
      return s;
   endfunction

   function automatic void queue_status(status_word_type s);
      status_expected.insert(status_expected.size(), s);
   endfunction

   task automatic send_frame(op_type op, track_type det);
      frame_word_type w;
      int gap;
      gap = req_gap_on ? pick_gap() : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      w = '0;
      w.cx = det.cx;
      w.cy = det.cy;
      w.slope = det.slope;
      w.yaw = det.yaw;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= w;
      do @(posedge clock); while (!req_tready);
      queue_status(predict_frame(op, det));
      frames_sent++;
   endtask

   // stop offering words and wait until every status word is back; ends on a rising edge
   task automatic drain_frames();
      @(negedge clock);
      req_tvalid <= 1'b0;
      do @(posedge clock); while (status_expected.size() != 0);
   endtask

   task automatic write_reg(logic [CsrAddrWidth-1:0] idx, int value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= value[CsrDataWidth-1:0];
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         RegConfirmFrames: lim_confirm = value & 'hFF;
         RegConfMissLimit: lim_conf_miss = value & 'hFF;
         RegPendMissLimit: lim_pend_miss = value & 'hFF;
         RegCenterLimit:   lim_center = value & 'hFFFF;
         RegSlopeLimit:    lim_slope = value & 'h1FFF;
         RegYawLimit:      lim_yaw = value & 'h7FFF;
         default: ;
      endcase
   endtask

   task automatic set_limits(int confirm, int conf_miss, int pend_miss, int center, int slope,
                             int yaw);
      drain_frames();
      write_reg(RegConfirmFrames, confirm);
      write_reg(RegConfMissLimit, conf_miss);
      write_reg(RegPendMissLimit, pend_miss);
      write_reg(RegCenterLimit, center);
      write_reg(RegSlopeLimit, slope);
      write_reg(RegYawLimit, yaw);
   endtask

   function automatic int jitter(int lim);
      int r, v;
      r = $urandom_range(0, 19);
      if (r == 0) v = lim + 1;
      else if (r == 1) v = lim;
      else v = $urandom_range(0, lim * 3 / 4);
      return $urandom_range(0, 1) ? -v : v;
   endfunction

   function automatic int clamp16(int v);
      if (v < -32768) return -32768;
      if (v > 32767) return 32767;
      return v;
   endfunction

   // a target drifting mostly within the limits, mixed with misses, clears, unused codes, noise and jumps
   task automatic run_track_stream(int count);
      track_type tgt, det;
      int r, s;
      tgt = random_track();
      repeat (count) begin
         r = $urandom_range(0, 99);
         if (r < 65) begin
            s = int'(tgt.slope) + jitter(lim_slope);
            if (s < 0) s = 0;
            if (s > 8191) s = 8191;
            det = make_track(clamp16(int'(tgt.cx) + jitter(lim_center)),
                             clamp16(int'(tgt.cy) + jitter(lim_center)),
                             s, int'(tgt.yaw) + jitter(lim_yaw));
            tgt = det;
            send_frame(OP_DET, det);
         end else if (r < 80) begin
            send_frame(OP_NO_DET, random_track());
         end else if (r < 83) begin
            send_frame(OP_CLEAR, random_track());
         end else if (r < 86) begin
            send_frame(OP_NONE, random_track());
         end else if (r < 94) begin
            send_frame(OP_DET, random_track());
         end else begin
            tgt = random_track();
            send_frame(OP_DET, tgt);
         end
      end
   endtask

   task automatic test_directed_defaults();
      send_frame(OP_NO_DET, make_track(0, 0, 0, 0));
      send_frame(OP_DET, make_track(1000, -2000, 100, 65000));
      send_frame(OP_DET, make_track(1100, -1900, 300, 65535));
      // yaw steps across zero
      send_frame(OP_DET, make_track(1200, -1800, 500, 1000));
      send_frame(OP_DET, make_track(1300, -1700, 700, 2000));
      send_frame(OP_DET, make_track(1400, -1600, 900, 3000));
      // center shift exactly on the limit, straight and diagonal
      send_frame(OP_DET, make_track(2000, -1600, 900, 3000));
      send_frame(OP_DET, make_track(2360, -1120, 900, 3000));
      // slope one past the limit: confirmed coasts, pending restarts
      send_frame(OP_DET, make_track(2360, -1120, 1447, 3000));
      repeat (3) send_frame(OP_NO_DET, random_track());
      send_frame(OP_NONE, make_track(-1, -1, 8191, 65535));
      // yaw change exactly on the limit
      send_frame(OP_DET, make_track(2360, -1120, 900, 5731));
      send_frame(OP_CLEAR, random_track());
      send_frame(OP_DET, make_track(-32768, 32767, 8191, 65535));
      send_frame(OP_DET, make_track(-32768, 32767, 7645, 2730));
      send_frame(OP_DET, make_track(32767, -32768, 0, 0));
      // half a turn of yaw never matches
      send_frame(OP_DET, make_track(32767, -32768, 0, 32768));
   endtask

   // widest limits and counters: hit count and both miss counters run up to 255
   task automatic test_count_saturation();
      set_limits(255, 255, 255, 65535, 8191, 32767);
      repeat (300) begin
         send_frame(OP_DET, make_track($urandom_range(0, 2000) - 1000,
                                       $urandom_range(0, 2000) - 1000,
                                       $urandom_range(0, 8191), $urandom_range(0, 65535)));
      end
      repeat (260) send_frame(OP_NO_DET, random_track());
   endtask

   task automatic test_tight_limits();
      set_limits(1, 0, 0, 1, 1, 1);
      send_frame(OP_DET, make_track(5, 5, 10, 10));
      send_frame(OP_DET, make_track(6, 5, 11, 11));
      send_frame(OP_DET, make_track(7, 6, 11, 11));
      send_frame(OP_NO_DET, random_track());
      send_frame(OP_DET, make_track(0, 0, 0, 0));
      send_frame(OP_DET, make_track(0, 0, 0, 65535));
      send_frame(OP_NONE, random_track());
   endtask

   // confirm count of zero behaves as one; zero limits need an exact repeat
   task automatic test_zero_limits();
      set_limits(0, 1, 1, 0, 0, 0);
      send_frame(OP_DET, make_track(100, -100, 4000, 40000));
      send_frame(OP_DET, make_track(100, -100, 4000, 40000));
      send_frame(OP_DET, make_track(101, -100, 4000, 40000));
      send_frame(OP_DET, make_track(101, -100, 4000, 40000));
      send_frame(OP_DET, make_track(101, -100, 4001, 40000));
      send_frame(OP_DET, make_track(101, -100, 4001, 40001));
   endtask

   // rsp held off long enough for the block to fill and drop req_tready
   task automatic test_rsp_backpressure();
      set_limits(3, 4, 2, 800, 600, 3000);
      req_gap_on = 1'b0;
      rsp_stall_on = 1'b0;
      rsp_hold_req = 200;
      run_track_stream(40);
      req_gap_on = 1'b1;
      rsp_stall_on = 1'b1;
   endtask

   task automatic test_random_tracks();
      int p;
      for (p = 0; p < 4; p++) begin
         req_gap_on = (p != 2);
         rsp_stall_on = (p != 2);
         set_limits($urandom_range(1, 6), $urandom_range(0, 10), $urandom_range(0, 4),
                    $urandom_range(1, 3000), $urandom_range(1, 1500), $urandom_range(1, 6000));
         run_track_stream(300);
      end
      req_gap_on = 1'b1;
      rsp_stall_on = 1'b1;
   endtask

   always @(negedge clock) begin
      if (rsp_hold_req > 0) begin
         rsp_hold_left = rsp_hold_req;
         rsp_hold_req = 0;
      end
      if (rsp_hold_left > 0) begin
         rsp_hold_left--;
         rsp_tready <= 1'b0;
      end else if (rsp_stall_left > 0) begin
         rsp_stall_left--;
         rsp_tready <= 1'b0;
      end else if (rsp_stall_on && $urandom_range(0, 3) == 0) begin
         rsp_stall_left = pick_gap();
         rsp_tready <= (rsp_stall_left == 0);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic check_field(string name, int want, int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         err_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_word = rsp_tdata;
         if (status_expected.size() == 0) begin
            $error("status word with no frame outstanding: %h", rsp_tdata);
            err_count++;
         end else begin
            want_word = status_expected.pop_front();
            check_field("confirmed_valid", int'(want_word.conf_on), int'(got_word.conf_on));
            check_field("pending_valid", int'(want_word.pend_on), int'(got_word.pend_on));
            check_field("track_x_mm", int'(want_word.x), int'(got_word.x));
            check_field("track_y_mm", int'(want_word.y), int'(got_word.y));
            check_field("track_slope", int'(want_word.slope), int'(got_word.slope));
            check_field("track_yaw", int'(want_word.yaw), int'(got_word.yaw));
            check_field("confirm_count", int'(want_word.hits), int'(got_word.hits));
            check_field("pending_misses", int'(want_word.pend_misses),
                        int'(got_word.pend_misses));
            check_field("confirmed_misses", int'(want_word.conf_misses),
                        int'(got_word.conf_misses));
            words_checked++;
         end
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_defaults();
      test_count_saturation();
      test_tight_limits();
      test_zero_limits();
      test_rsp_backpressure();
      test_random_tracks();
      drain_frames();
      repeat (4) @(posedge clock);
      $display("%0d frames sent, %0d status words checked, %0d track confirmations",
               frames_sent, words_checked, confirm_events);
      $display("reset defaults, saturated counters, tight and zero limits, long rsp stall, "
               , "random drifting tracks");
      if (err_count == 0) begin
         $display("tb_detection_track_confirmation: done, clean");
      end else begin
         $display("tb_detection_track_confirmation: done, errors");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/dtc_pkg.sv
hdl/detection_track_confirmation.sv
test/tb_detection_track_confirmation.sv
